// ===== design/ptc_pkg.sv =====
// types, codes and helpers shared by the timer/counter with capture
`default_nettype none

package ptc_pkg;

  typedef struct packed {
    logic [9:0] prescale_count;
    logic       ext_clock_pin;
    logic       capture_pin;
  } in_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic        out_a_level;
    logic        out_b_level;
    logic        overflow_flag;
    logic        match_a_flag;
    logic        match_b_flag;
    logic        capture_flag;
    logic [15:0] capture_value;
  } out_t;

  typedef enum logic [1:0] {
    RegControlA = 2'd0,
    RegControlB = 2'd1,
    RegCompareA = 2'd2,
    RegCompareB = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ClkStop    = 3'd0,
    ClkDiv1    = 3'd1,
    ClkDiv8    = 3'd2,
    ClkDiv64   = 3'd3,
    ClkDiv256  = 3'd4,
    ClkDiv1024 = 3'd5,
    ClkExtFall = 3'd6,
    ClkExtRise = 3'd7
  } clk_sel_e;

  typedef enum logic [1:0] {
    ResNormal = 2'd0,
    Res8Bit   = 2'd1,
    Res9Bit   = 2'd2,
    Res10Bit  = 2'd3
  } pwm_res_e;

  typedef enum logic [1:0] {
    ModeOff    = 2'd0,
    ModeToggle = 2'd1,
    ModeClear  = 2'd2,
    ModeSet    = 2'd3
  } out_mode_e;

  localparam logic [15:0] Top8Bit  = 16'h00ff;
  localparam logic [15:0] Top9Bit  = 16'h01ff;
  localparam logic [15:0] Top10Bit = 16'h03ff;

  localparam logic [2:0] FilterNoiseLimit = 3'd3;

  // new compare output level on a match
  function automatic logic apply_mode(input out_mode_e mode, input logic pwm,
                                      input logic down, input logic level);
    logic res;
    res = level;
    if (!pwm) begin
      case (mode)
        ModeToggle: res = ~level;
        ModeClear:  res = 1'b0;
        ModeSet:    res = 1'b1;
        default:    res = level;
      endcase
    end else begin
      case (mode)
        ModeClear: res = down;
        ModeSet:   res = ~down;
        default:   res = level;
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/pwm_timer_counter_with_capture.sv =====
// top level: 16-bit timer/counter with phase-correct pwm, two compare units and input capture
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid_i / in_ready_o          | into      | in_data_i (ptc_pkg::in_t)
//  out     | out_valid_o / out_ready_i        | out of    | out_data_o (ptc_pkg::out_t)
//  cfg     | cfg_valid_i / cfg_ready_o        | into      | cfg_index_i, cfg_data_i
//
// one item a cycle unless out stalls: each item is worked in a single pass from
// the timer state into the result register, so an accepted item shows on out in
// the next cycle. the result register frees whenever it is taken, so in stalls
// only while a result waits and out_ready_i is low. reset clears counter,
// direction, output levels, pin history, filter and captured value; cfg is always ready.
`default_nettype none

module pwm_timer_counter_with_capture #(
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire ptc_pkg::in_t        in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      ptc_pkg::out_t       out_data_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire ptc_pkg::cfg_reg_e   cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  import ptc_pkg::*;

  logic [7:0]  control_a_q;
  logic [7:0]  control_b_q;
  logic [15:0] compare_a_q;
  logic [15:0] compare_b_q;

  logic [15:0] counter_q, counter_d;
  logic        down_q, down_d;
  logic        out_a_q, out_a_d;
  logic        out_b_q, out_b_d;
  logic        ext_prev_q;
  logic        cap_prev_q;
  logic [2:0]  filter_q, filter_d;
  logic [15:0] captured_q, captured_d;

  logic        out_valid_q;
  out_t        out_q, out_d;

  logic        accept;
  logic        pwm;
  logic [15:0] top;
  logic        tick;
  logic [15:0] stepped;
  logic [15:0] cleared;
  logic        ovf, ma, mb, cf;
  logic [2:0]  filt_next;
  logic [2:0]  filt_limit;
  clk_sel_e    sel;
  pwm_res_e    res;

  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign res = pwm_res_e'(control_a_q[1:0]);
  assign sel = clk_sel_e'(control_b_q[2:0]);
  assign pwm = (res != ResNormal);

  always_comb begin
    unique case (res)
      Res8Bit:  top = Top8Bit;
      Res9Bit:  top = Top9Bit;
      default:  top = Top10Bit;
    endcase
  end

  always_comb begin
    unique case (sel)
      ClkStop:    tick = 1'b0;
      ClkDiv1:    tick = 1'b1;
      ClkDiv8:    tick = (in_data_i.prescale_count[2:0] == 3'd0);
      ClkDiv64:   tick = (in_data_i.prescale_count[5:0] == 6'd0);
      ClkDiv256:  tick = (in_data_i.prescale_count[7:0] == 8'd0);
      ClkDiv1024: tick = (in_data_i.prescale_count == 10'd0);
      ClkExtFall: tick = ~in_data_i.ext_clock_pin & ext_prev_q;
      default:    tick = in_data_i.ext_clock_pin & ~ext_prev_q;
    endcase
  end

  // counting, direction turn, overflow and compare matches
  always_comb begin
    counter_d = counter_q;
    down_d    = down_q;
    out_a_d   = out_a_q;
    out_b_d   = out_b_q;
    ovf       = 1'b0;
    ma        = 1'b0;
    mb        = 1'b0;
    stepped   = (pwm && down_q) ? counter_q - 16'd1 : counter_q + 16'd1;
    cleared   = stepped;
    if (tick) begin
      if (pwm) begin
        if (stepped == 16'd0 && down_q) begin
          down_d = 1'b0;
        end
        if (stepped == top && !down_d) begin
          down_d = 1'b1;
        end
      end
      ovf = (stepped == 16'd1) && !down_d;
      if (stepped == compare_a_q) begin
        if (control_b_q[3]) begin
          cleared = 16'd0;
        end
        out_a_d = apply_mode(out_mode_e'(control_a_q[7:6]), pwm, down_d, out_a_q);
        ma      = 1'b1;
      end
      // compare b sees the counter after any clear
      if (cleared == compare_b_q) begin
        out_b_d = apply_mode(out_mode_e'(control_a_q[5:4]), pwm, down_d, out_b_q);
        mb      = 1'b1;
      end
      counter_d = cleared;
    end
  end

  // capture edge detect and noise filter
  always_comb begin
    if (in_data_i.capture_pin != cap_prev_q && in_data_i.capture_pin == control_b_q[6]) begin
      filt_next = 3'd1;
    end else if (filter_q != 3'd0 && in_data_i.capture_pin == control_b_q[6]) begin
      filt_next = filter_q + 3'd1;
    end else begin
      filt_next = 3'd0;
    end
    filt_limit = control_b_q[7] ? FilterNoiseLimit : 3'd0;
    cf         = (filt_next > filt_limit);
    filter_d   = cf ? 3'd0 : filt_next;
    captured_d = cf ? counter_d : captured_q;
  end

  always_comb begin
    out_d.count_value   = counter_d;
    out_d.out_a_level   = out_a_d;
    out_d.out_b_level   = out_b_d;
    out_d.overflow_flag = ovf;
    out_d.match_a_flag  = ma;
    out_d.match_b_flag  = mb;
    out_d.capture_flag  = cf;
    out_d.capture_value = captured_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_a_q <= '0;
      control_b_q <= '0;
      compare_a_q <= '0;
      compare_b_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegControlA: control_a_q <= cfg_data_i[7:0];
        RegControlB: control_b_q <= cfg_data_i[7:0];
        RegCompareA: compare_a_q <= cfg_data_i;
        default:     compare_b_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      down_q      <= 1'b0;
      out_a_q     <= 1'b0;
      out_b_q     <= 1'b0;
      ext_prev_q  <= 1'b0;
      cap_prev_q  <= 1'b0;
      filter_q    <= '0;
      captured_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        counter_q  <= counter_d;
        down_q     <= down_d;
        out_a_q    <= out_a_d;
        out_b_q    <= out_b_d;
        ext_prev_q <= in_data_i.ext_clock_pin;
        cap_prev_q <= in_data_i.capture_pin;
        filter_q   <= filter_d;
        captured_q <= captured_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire
